/* sv/bdlp_pkg.sv */
// Shared types and constants for the button debouncer with long-press detection
`default_nettype none
package bdlp_pkg;

	localparam int MAX_BUTTONS = 4;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int LIMIT_W     = 16;
	localparam int SINCE_W     = 16;

	typedef enum logic [1:0] {
		KIND_RELEASED = 2'd0,
		KIND_PRESSED  = 2'd1,
		KIND_LONG     = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_DEBOUNCE = 3'd0,
		REG_HOLD0    = 3'd1,
		REG_HOLD1    = 3'd2,
		REG_HOLD2    = 3'd3,
		REG_HOLD3    = 3'd4
	} reg_idx_t;

	// one queued item: result kind plus the set of buttons it reports
	typedef struct packed {
		kind_t                  kind;
		logic [MAX_BUTTONS-1:0] mask;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} qbeat_t;

endpackage
`default_nettype wire

/* sv/bdlp_front.sv */
// Front end: takes ticks and pin events, keeps debounce and hold state, classifies results
`default_nettype none
module bdlp_front import bdlp_pkg::*; #(
	parameter int NUM_BUTTONS = 4,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic [1:0]                        pin,
	input  logic                              level,
	input  logic [SINCE_W-1:0]                debounce_ticks,
	input  logic [MAX_BUTTONS-1:0][LIMIT_W-1:0] hold_limit,
	input  logic                              q_full,
	output qbeat_t                            push
);

	localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
	localparam logic [COUNT_WIDTH-1:0] HOLD_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [SINCE_W-1:0]     SINCE_MAX = {SINCE_W{1'b1}};

	logic [SINCE_W-1:0]     since_q, since_d;
	logic [NUM_BUTTONS-1:0] holding_q, holding_d;
	logic [COUNT_WIDTH-1:0] cnt_q [NUM_BUTTONS];
	logic [COUNT_WIDTH-1:0] cnt_d [NUM_BUTTONS];
	logic [COUNT_WIDTH-1:0] inc;
	logic [MAX_BUTTONS-1:0] res_mask;
	kind_t                  res_kind;
	logic                   accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		since_d  = since_q;
		holding_d = holding_q;
		cnt_d    = cnt_q;
		res_mask = '0;
		res_kind = KIND_LONG;
		inc      = '0;
		if (accept) begin
			if (!op) begin
				if (since_q != SINCE_MAX)
					since_d = since_q + SINCE_W'(1);
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (holding_q[i]) begin
						inc = (cnt_q[i] == HOLD_MAX) ? cnt_q[i] : cnt_q[i] + COUNT_WIDTH'(1);
						cnt_d[i] = inc;
						if (CMP_W'(inc) > CMP_W'(hold_limit[i])) begin
							holding_d[i] = 1'b0;
							res_mask[i]  = 1'b1;
						end
					end
				end
			end else begin
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (pin == 2'(i)) begin
						if (since_q < debounce_ticks) begin
							// bounced: a release still ends the hold
							if (level)
								holding_d[i] = 1'b0;
						end else begin
							since_d     = '0;
							res_mask[i] = 1'b1;
							if (level) begin
								holding_d[i] = 1'b0;
								res_kind     = KIND_RELEASED;
							end else begin
								holding_d[i] = 1'b1;
								cnt_d[i]     = '0;
								res_kind     = KIND_PRESSED;
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q   <= SINCE_MAX;
			holding_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++)
				cnt_q[i] <= '0;
		end else begin
			since_q   <= since_d;
			holding_q <= holding_d;
			cnt_q     <= cnt_d;
		end
	end

	assign push.valid      = accept && (res_mask != '0);
	assign push.entry.kind = res_kind;
	assign push.entry.mask = res_mask;

	// a press or release reports exactly one button
	a_event_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.entry.kind != KIND_LONG |-> $onehot(push.entry.mask))
		else $error("event beat reports more than one button");

endmodule
`default_nettype wire

/* sv/bdlp_queue.sv */
// Short queue of classified result sets between front and back
`default_nettype none
module bdlp_queue import bdlp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  qbeat_t push,
	output logic   full,
	output qbeat_t head,
	input  logic   pop
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_pop;

	assign full       = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.entry = mem_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid && !full)
			mem_q[wr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid && !full)
				wr_q <= wr_q + QPTR_W'(1);
			if (do_pop)
				rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + (QPTR_W+1)'(push.valid && !full) - (QPTR_W+1)'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("push into full queue");

endmodule
`default_nettype wire

/* sv/bdlp_back.sv */
// Back end: expands a queued result set into one output beat per button
`default_nettype none
module bdlp_back import bdlp_pkg::*; #(
	parameter int NUM_BUTTONS = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  qbeat_t     head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] event_kind,
	output logic [1:0] button,
	output logic       last
);

	logic [MAX_BUTTONS-1:0] mask_q, mask_rest;
	kind_t                  kind_q;
	logic [1:0]             sel;

	assign out_valid = (mask_q != '0);

	always_comb begin
		sel = '0;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--)
			if (mask_q[i])
				sel = 2'(i);
	end

	assign mask_rest  = mask_q & (mask_q - MAX_BUTTONS'(1));
	assign last       = (mask_rest == '0);
	assign button     = sel;
	assign event_kind = kind_q;
	assign pop        = head.valid && (!out_valid || (out_ready && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			kind_q <= KIND_RELEASED;
		end else if (pop) begin
			mask_q <= head.entry.mask;
			kind_q <= head.entry.kind;
		end else if (out_valid && out_ready) begin
			mask_q <= mask_rest;
		end
	end

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last && !head.valid |=> !out_valid)
		else $error("output still valid after final beat");

	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && kind_q == $past(kind_q))
		else $error("result set cut short");

endmodule
`default_nettype wire

/* sv/button_debounce_long_press.sv */
// Top level: APB register bank, front end, result queue and back end
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  in       | in_valid / in_ready     | op, pin, level
//  out      | out_valid / out_ready   | event_kind, button, last
//  apb      | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// One item is taken per cycle while the four-entry result queue has room.
// A result set leaves at one beat per cycle while out_ready is high, so a tick that ends k holds
// takes k output beats; items behind it keep flowing into the queue.
// Reset clears the queue, debounce window, holds and counters, and loads
// register defaults (debounce 50, hold limits 1000).
// A stalled output back-pressures only once the queue fills.
`default_nettype none
module button_debounce_long_press import bdlp_pkg::*; #(
	parameter int NUM_BUTTONS = 4,
	parameter int COUNT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [1:0]  pin,
	input  logic        level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_kind,
	output logic [1:0]  button,
	output logic        last
);

	logic [SINCE_W-1:0]                 debounce_q;
	logic [MAX_BUTTONS-1:0][LIMIT_W-1:0] limit_q;
	logic [2:0]                         ridx;
	logic                               wr_en;
	qbeat_t                             push, head;
	logic                               q_full, pop;

	assign pready = 1'b1;
	assign ridx   = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= SINCE_W'(50);
			for (int i = 0; i < MAX_BUTTONS; i++)
				limit_q[i] <= LIMIT_W'(1000);
		end else if (wr_en) begin
			unique case (ridx)
				REG_DEBOUNCE: debounce_q <= pwdata[SINCE_W-1:0];
				REG_HOLD0:    limit_q[0] <= pwdata[LIMIT_W-1:0];
				REG_HOLD1:    limit_q[1] <= pwdata[LIMIT_W-1:0];
				REG_HOLD2:    limit_q[2] <= pwdata[LIMIT_W-1:0];
				REG_HOLD3:    limit_q[3] <= pwdata[LIMIT_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_DEBOUNCE: prdata = 32'(debounce_q);
			REG_HOLD0:    prdata = 32'(limit_q[0]);
			REG_HOLD1:    prdata = 32'(limit_q[1]);
			REG_HOLD2:    prdata = 32'(limit_q[2]);
			REG_HOLD3:    prdata = 32'(limit_q[3]);
			default:      prdata = '0;
		endcase
	end

	bdlp_front #(
		.NUM_BUTTONS (NUM_BUTTONS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.pin            (pin),
		.level          (level),
		.debounce_ticks (debounce_q),
		.hold_limit     (limit_q),
		.q_full         (q_full),
		.push           (push)
	);

	bdlp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	bdlp_back #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.button     (button),
		.last       (last)
	);

endmodule
`default_nettype wire
